// File: hw/rtl/rsh_pkg.sv
// Package for the removable storage health tracker.
// Holds the state, operation and register-index codes and the structs used by the update
// logic and the top level; the checker uses the state codes. No dependencies.
package rsh_pkg;

    typedef enum logic [1:0] {
        MEDIUM_ABSENT  = 2'd0,
        MEDIUM_READY   = 2'd1,
        MEDIUM_FAULTED = 2'd2
    } medium_state_t;

    typedef enum logic [1:0] {
        OP_START     = 2'd0,
        OP_IO_RESULT = 2'd1,
        OP_DUE_CHECK = 2'd2,
        OP_PROBE     = 2'd3
    } op_t;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAILURE_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_INTERVAL    = 1'b1;

    localparam logic [7:0]  RUN_MAX               = 8'hFF;
    localparam logic [7:0]  THRESHOLD_RESET       = 8'd1;
    localparam logic [31:0] PROBE_INTERVAL_RESET  = 32'd1000;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic        io_ok;
        logic        medium_present;
        logic        mount_succeeded;
    } item_t;

    typedef struct packed {
        logic [7:0]  failure_threshold;
        logic [31:0] probe_interval;
    } cfg_t;

    typedef struct packed {
        medium_state_t medium_state;
        logic [7:0]    failure_run;
        logic [31:0]   last_probe_time;
        logic [31:0]   mounts_total;
        logic [31:0]   faults_total;
    } track_t;

    typedef struct packed {
        medium_state_t storage_state;
        logic          state_event;
        logic          probe_due;
        logic [31:0]   mount_count;
        logic [31:0]   fault_count;
    } result_t;

endpackage

// File: hw/rtl/rsh_update.sv
// Single-pass update logic of the storage health tracker.
// Computes the next tracker state and the result beat for one item.
// Depends on rsh_pkg.
module rsh_update (
    input  rsh_pkg::item_t   item,
    input  rsh_pkg::cfg_t    cfg,
    input  rsh_pkg::track_t  cur,
    output rsh_pkg::track_t  nxt,
    output rsh_pkg::result_t res
);

    logic [7:0] thr_eff;
    logic [7:0] run_inc;
    logic [31:0] elapsed;

    assign thr_eff = (cfg.failure_threshold == 8'd0) ? 8'd1 : cfg.failure_threshold;
    assign run_inc = (cur.failure_run < rsh_pkg::RUN_MAX) ? cur.failure_run + 8'd1
                                                         : rsh_pkg::RUN_MAX;
    assign elapsed = item.now_ms - cur.last_probe_time;

    // next state
    always_comb begin
        nxt = cur;
        unique case (item.op)
            rsh_pkg::OP_START: begin
                nxt.medium_state    = rsh_pkg::MEDIUM_ABSENT;
                nxt.failure_run     = 8'd0;
                nxt.last_probe_time = item.now_ms - cfg.probe_interval;
                nxt.mounts_total    = 32'd0;
                nxt.faults_total    = 32'd0;
            end
            rsh_pkg::OP_IO_RESULT: begin
                if (cur.medium_state == rsh_pkg::MEDIUM_READY) begin
                    if (item.io_ok) begin
                        nxt.failure_run = 8'd0;
                    end else begin
                        nxt.failure_run = run_inc;
                        if (run_inc >= thr_eff) begin
                            nxt.medium_state = rsh_pkg::MEDIUM_FAULTED;
                            nxt.faults_total = cur.faults_total + 32'd1;
                        end
                    end
                end
            end
            rsh_pkg::OP_DUE_CHECK: begin
                nxt = cur;
            end
            rsh_pkg::OP_PROBE: begin
                nxt.last_probe_time = item.now_ms;
                nxt.failure_run     = 8'd0;
                if (item.medium_present && item.mount_succeeded) begin
                    nxt.medium_state = rsh_pkg::MEDIUM_READY;
                    if (cur.medium_state != rsh_pkg::MEDIUM_READY) begin
                        nxt.mounts_total = cur.mounts_total + 32'd1;
                    end
                end else begin
                    nxt.medium_state = rsh_pkg::MEDIUM_ABSENT;
                end
            end
        endcase
    end

    // result beat
    always_comb begin
        res.storage_state = nxt.medium_state;
        res.mount_count   = nxt.mounts_total;
        res.fault_count   = nxt.faults_total;
        res.state_event   = 1'b0;
        res.probe_due     = 1'b0;
        unique case (item.op)
            rsh_pkg::OP_START: begin
                res.state_event = 1'b0;
            end
            rsh_pkg::OP_IO_RESULT: begin
                res.state_event = (nxt.medium_state == rsh_pkg::MEDIUM_FAULTED) &&
                                  (cur.medium_state == rsh_pkg::MEDIUM_READY);
            end
            rsh_pkg::OP_DUE_CHECK: begin
                res.probe_due = (cur.medium_state != rsh_pkg::MEDIUM_READY) &&
                                (elapsed >= cfg.probe_interval);
            end
            rsh_pkg::OP_PROBE: begin
                res.state_event = (nxt.medium_state != cur.medium_state);
            end
        endcase
    end

endmodule

// File: hw/rtl/removable_storage_health_fsm.sv
// Removable storage health tracker, top level: input register, update logic, result
// register, tracker state and configuration registers. Uses rsh_pkg, rsh_update.
// Beats pass the input register, then the result register; one item per cycle unless stalled.
// Stalls: the result register holds while m_tready is low; the input register holds behind it.
// Reset (aresetn low, synchronous): state absent, counters and probe time zero,
// threshold 1, probe interval 1000, both channels empty.
module removable_storage_health_fsm (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms[31:0], io_ok, medium_present, mount_succeeded, zeros
    input  logic [rsh_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [rsh_pkg::S_TUSER_W-1:0] s_tuser,  // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // storage_state[1:0], state_event, probe_due, mount_count[31:0], fault_count[31:0], zeros
    output logic [rsh_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [rsh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic             in_valid_reg;
    rsh_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    rsh_pkg::result_t out_res_reg;
    rsh_pkg::track_t  track_reg;
    rsh_pkg::track_t  track_next;
    rsh_pkg::result_t res_next;
    rsh_pkg::cfg_t    cfg_reg;
    rsh_pkg::item_t   s_item;
    logic             advance;
    logic             s_accept;

    assign s_item.op              = rsh_pkg::op_t'(s_tuser);
    assign s_item.now_ms          = s_tdata[31:0];
    assign s_item.io_ok           = s_tdata[32];
    assign s_item.medium_present  = s_tdata[33];
    assign s_item.mount_succeeded = s_tdata[34];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && !m_tready);

    rsh_update u_update (
        .item (in_item_reg),
        .cfg  (cfg_reg),
        .cur  (track_reg),
        .nxt  (track_next),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            track_reg     <= '{medium_state: rsh_pkg::MEDIUM_ABSENT, default: '0};
            cfg_reg.failure_threshold <= rsh_pkg::THRESHOLD_RESET;
            cfg_reg.probe_interval    <= rsh_pkg::PROBE_INTERVAL_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (advance) begin
                track_reg <= track_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    rsh_pkg::CFG_FAILURE_THRESHOLD: cfg_reg.failure_threshold <= cfg_wdata[7:0];
                    rsh_pkg::CFG_PROBE_INTERVAL:    cfg_reg.probe_interval    <= cfg_wdata;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.fault_count, out_res_reg.mount_count,
                       out_res_reg.probe_due, out_res_reg.state_event,
                       out_res_reg.storage_state};

endmodule

// File: hw/rtl/rsh_checker.sv
// Port-level checker for the removable storage health tracker, bound to the top level.
// Depends on rsh_pkg and removable_storage_health_fsm.
module rsh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat shown right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed or dropped");

    a_state_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == rsh_pkg::MEDIUM_ABSENT) ||
                     (m_tdata[1:0] == rsh_pkg::MEDIUM_READY) ||
                     (m_tdata[1:0] == rsh_pkg::MEDIUM_FAULTED))
        else $error("storage state out of range");

    a_due_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[1:0] != rsh_pkg::MEDIUM_READY && !m_tdata[2])
        else $error("probe due while ready or together with a state event");

endmodule

bind removable_storage_health_fsm rsh_checker u_rsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/rsh_tb_pkg.sv
`timescale 1ns / 100ps
// Storage health predictor and result scoreboard for the health tracker bench.
// Depends on rsh_pkg for the item, result, state and register types.
package rsh_tb_pkg;

    class health_scoreboard;
        rsh_pkg::cfg_t    cfg;
        rsh_pkg::track_t  track;
        rsh_pkg::result_t awaited[$];
        int               mismatches;
        int               checked;

        function new();
            cfg.failure_threshold = rsh_pkg::THRESHOLD_RESET;
            cfg.probe_interval    = rsh_pkg::PROBE_INTERVAL_RESET;
            track      = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_register(logic [rsh_pkg::CFG_INDEX_W-1:0] index,
                                     logic [31:0] value);
            if (index == rsh_pkg::CFG_FAILURE_THRESHOLD) begin
                cfg.failure_threshold = value[7:0];
            end else begin
                cfg.probe_interval = value;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_item(rsh_pkg::item_t it);
            rsh_pkg::result_t       res;
            rsh_pkg::medium_state_t prior;
            logic [7:0]             limit;
            logic [31:0]            elapsed;
            res = '0;
            case (it.op)
                rsh_pkg::OP_START: begin
                    track = '0;
                    track.last_probe_time = it.now_ms - cfg.probe_interval;
                end
                rsh_pkg::OP_IO_RESULT: begin
                    if (track.medium_state == rsh_pkg::MEDIUM_READY) begin
                        if (it.io_ok) begin
                            track.failure_run = '0;
                        end else begin
                            limit = (cfg.failure_threshold == 8'd0) ? 8'd1 :
                                    cfg.failure_threshold;
                            if (track.failure_run != rsh_pkg::RUN_MAX) begin
                                track.failure_run = track.failure_run + 8'd1;
                            end
                            if (track.failure_run >= limit) begin
                                track.medium_state = rsh_pkg::MEDIUM_FAULTED;
                                track.faults_total = track.faults_total + 32'd1;
                                res.state_event    = 1'b1;
                            end
                        end
                    end
                end
                rsh_pkg::OP_DUE_CHECK: begin
                    elapsed = it.now_ms - track.last_probe_time;
                    res.probe_due = (track.medium_state != rsh_pkg::MEDIUM_READY) &&
                                    (elapsed >= cfg.probe_interval);
                end
                default: begin
                    prior = track.medium_state;
                    track.last_probe_time = it.now_ms;
                    track.failure_run     = '0;
                    if (it.medium_present && it.mount_succeeded) begin
                        track.medium_state = rsh_pkg::MEDIUM_READY;
                        if (prior != rsh_pkg::MEDIUM_READY) begin
                            track.mounts_total = track.mounts_total + 32'd1;
                        end
                    end else begin
                        track.medium_state = rsh_pkg::MEDIUM_ABSENT;
                    end
                    res.state_event = (track.medium_state != prior);
                end
            endcase
            res.storage_state = track.medium_state;
            res.mount_count   = track.mounts_total;
            res.fault_count   = track.faults_total;
            awaited.push_back(res);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(rsh_pkg::result_t got);
            rsh_pkg::result_t want;
            if (awaited.size() == 0) begin
                $error("result beat with no prediction pending (storage_state %0d)",
                       got.storage_state);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            check_field("storage_state", 32'(want.storage_state), 32'(got.storage_state));
            check_field("state_event", 32'(want.state_event), 32'(got.state_event));
            check_field("probe_due", 32'(want.probe_due), 32'(got.probe_due));
            check_field("mount_count", want.mount_count, got.mount_count);
            check_field("fault_count", want.fault_count, got.fault_count);
        endfunction
    endclass

endpackage

// File: tb/sv/removable_storage_health_fsm_tb.sv
`timescale 1ns / 100ps
// Top-level bench for removable_storage_health_fsm: directed and random beats under
// several register settings, with random idle and stall bursts in all but the last. Uses rsh_pkg, rsh_tb_pkg.
module removable_storage_health_fsm_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;  // now_ms[31:0], io_ok, medium_present, mount_succeeded, zeros
    logic [1:0]  s_tuser   = '0;  // operation[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // storage_state[1:0], state_event, probe_due, mount_count[31:0], fault_count[31:0], zeros
    logic [71:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    rsh_tb_pkg::health_scoreboard sb;
    rsh_pkg::result_t             beat_result;
    bit                           idle_en    = 1'b1;
    int                           items_sent = 0;
    int                           settings   = 1;
    int                           cycles     = 0;
    logic [31:0]                  cur_time   = '0;

    removable_storage_health_fsm uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beat_result.storage_state = rsh_pkg::medium_state_t'(m_tdata[1:0]);
            beat_result.state_event   = m_tdata[2];
            beat_result.probe_due     = m_tdata[3];
            beat_result.mount_count   = m_tdata[35:4];
            beat_result.fault_count   = m_tdata[67:36];
            sb.check_result(beat_result);
        end
    end

    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (aresetn && idle_en && $urandom_range(0, 7) == 0) begin
                stall    = $urandom_range(1, 16);
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_item(rsh_pkg::op_t op, logic [31:0] now, logic ok, logic present,
                             logic mounted);
        rsh_pkg::item_t it;
        int             gap;
        it.op              = op;
        it.now_ms          = now;
        it.io_ok           = ok;
        it.medium_present  = present;
        it.mount_succeeded = mounted;
        gap = (idle_en && $urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = {5'b0, mounted, present, ok, now};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
        cur_time = now;
        items_sent++;
    endtask

    task automatic write_reg(logic [0:0] index, logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_wdata = value;
        @(posedge aclk);
        sb.write_register(index, value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return cur_time + $urandom_range(0, 300);
            5, 6:          return cur_time + $urandom_range(0, 3000);
            7:             return sb.track.last_probe_time + sb.cfg.probe_interval
                                  + $urandom_range(0, 2) - 32'd1;
            8:             return $urandom;
            default:       return cur_time - $urandom_range(0, 100);
        endcase
    endfunction

    task automatic run_random(int budget);
        int   target;
        int   burst;
        int   ok_pct;
        int   limit;
        logic both;
        target = items_sent + budget;
        while (items_sent < target) begin
            limit = (sb.cfg.failure_threshold == 8'd0) ? 1 : int'(sb.cfg.failure_threshold);
            case ($urandom_range(0, 19))
                0: begin
                    send_item(rsh_pkg::OP_START, pick_time(), 1'($urandom), 1'($urandom),
                              1'($urandom));
                    send_item(rsh_pkg::OP_DUE_CHECK, pick_time(), 1'($urandom),
                              1'($urandom), 1'($urandom));
                end
                1, 2, 3, 4, 5, 6: begin
                    both = ($urandom_range(0, 9) < 7);
                    send_item(rsh_pkg::OP_PROBE, pick_time(), 1'($urandom),
                              1'(both | $urandom_range(0, 1)),
                              1'(both | $urandom_range(0, 1)));
                end
                7, 8, 9, 10: begin
                    send_item(rsh_pkg::OP_DUE_CHECK, pick_time(), 1'($urandom),
                              1'($urandom), 1'($urandom));
                end
                11, 12, 13, 14, 15, 16, 17: begin
                    if ($urandom_range(0, 1)) begin
                        send_item(rsh_pkg::OP_PROBE, pick_time(), 1'($urandom), 1'b1, 1'b1);
                    end
                    burst  = $urandom_range(0, 1) ? limit + $urandom_range(0, 2) :
                             $urandom_range(1, limit);
                    ok_pct = $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
                    repeat (burst) begin
                        send_item(rsh_pkg::OP_IO_RESULT, pick_time(),
                                  $urandom_range(0, 99) < ok_pct, 1'($urandom), 1'($urandom));
                    end
                end
                default: begin
                    send_item(rsh_pkg::op_t'($urandom_range(0, 3)), $urandom, 1'($urandom),
                              1'($urandom), 1'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        logic [31:0] wvalue;
        sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_item(rsh_pkg::OP_DUE_CHECK, 32'd0, 1'b0, 1'b0, 1'b0);
        send_item(rsh_pkg::OP_DUE_CHECK, 32'd1000, 1'b0, 1'b0, 1'b0);
        send_item(rsh_pkg::OP_IO_RESULT, 32'd0, 1'b0, 1'b0, 1'b0);
        send_item(rsh_pkg::OP_START, 32'd0, 1'b1, 1'b1, 1'b1);
        send_item(rsh_pkg::OP_DUE_CHECK, 32'd0, 1'b0, 1'b0, 1'b0);
        send_item(rsh_pkg::OP_DUE_CHECK, 32'hFFFF_FC18, 1'b0, 1'b0, 1'b0);
        send_item(rsh_pkg::OP_PROBE, 32'd5, 1'b0, 1'b1, 1'b0);
        send_item(rsh_pkg::OP_PROBE, 32'd6, 1'b0, 1'b0, 1'b1);
        send_item(rsh_pkg::OP_PROBE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        send_item(rsh_pkg::OP_DUE_CHECK, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1);
        send_item(rsh_pkg::OP_IO_RESULT, 32'd0, 1'b1, 1'b0, 1'b0);
        send_item(rsh_pkg::OP_IO_RESULT, 32'd0, 1'b0, 1'b1, 1'b1);
        send_item(rsh_pkg::OP_IO_RESULT, 32'd0, 1'b0, 1'b0, 1'b0);
        send_item(rsh_pkg::OP_DUE_CHECK, 32'd999, 1'b0, 1'b0, 1'b0);
        send_item(rsh_pkg::OP_PROBE, 32'd1000, 1'b0, 1'b1, 1'b1);
        send_item(rsh_pkg::OP_PROBE, 32'd2000, 1'b1, 1'b1, 1'b1);
        send_item(rsh_pkg::OP_PROBE, 32'd3000, 1'b0, 1'b0, 1'b0);
        send_item(rsh_pkg::OP_PROBE, 32'd4000, 1'b0, 1'b1, 1'b1);
        send_item(rsh_pkg::OP_IO_RESULT, 32'd4001, 1'b0, 1'b0, 1'b0);
        send_item(rsh_pkg::OP_PROBE, 32'd5000, 1'b0, 1'b1, 1'b0);
        send_item(rsh_pkg::OP_START, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_item(rsh_pkg::OP_DUE_CHECK, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        run_random(250);

        drain_results();
        write_reg(rsh_pkg::CFG_FAILURE_THRESHOLD, 32'd3);
        write_reg(rsh_pkg::CFG_PROBE_INTERVAL, 32'd0);
        settings++;
        run_random(250);

        drain_results();
        wvalue = $urandom;
        wvalue[7:0] = 8'h00;
        write_reg(rsh_pkg::CFG_FAILURE_THRESHOLD, wvalue);
        write_reg(rsh_pkg::CFG_PROBE_INTERVAL, 32'hFFFF_FFFF);
        settings++;
        run_random(250);

        drain_results();
        wvalue = $urandom;
        wvalue[7:0] = 8'hFF;
        write_reg(rsh_pkg::CFG_FAILURE_THRESHOLD, wvalue);
        write_reg(rsh_pkg::CFG_PROBE_INTERVAL, $urandom);
        settings++;
        send_item(rsh_pkg::OP_PROBE, pick_time(), 1'b0, 1'b1, 1'b1);
        repeat (255) begin
            send_item(rsh_pkg::OP_IO_RESULT, pick_time(), 1'b0, 1'($urandom), 1'($urandom));
        end
        run_random(250);

        drain_results();
        idle_en = 1'b0;
        write_reg(rsh_pkg::CFG_FAILURE_THRESHOLD, $urandom_range(2, 8));
        write_reg(rsh_pkg::CFG_PROBE_INTERVAL, $urandom_range(1, 5000));
        settings++;
        run_random(250);

        drain_results();
        $display("Checked %0d result beats from %0d input beats over %0d register settings",
                 sb.checked, items_sent, settings);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
